/* hw/rtl/lssc_pkg.sv */
// ----------------------------------------------------------------------------
// lssc_pkg
// Shared types and constants for the line-sensor steering classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package lssc_pkg;

  // Fixed field widths of the frame and result beats
  localparam int SAMPLE_FIELD_BITS = 10;
  localparam int MAX_CHANNELS      = 12;
  localparam int CLASS_BITS        = 3;

  typedef logic [SAMPLE_FIELD_BITS-1:0] sample_t;
  typedef logic [CLASS_BITS-1:0]        class_t;
  typedef logic [MAX_CHANNELS-1:0]      above_t;

  // Steering class codes
  localparam class_t CLASS_OFF_LEFT  = 3'd0;
  localparam class_t CLASS_OFF_RIGHT = 3'd1;
  localparam class_t CLASS_STRAIGHT  = 3'd2;
  localparam class_t CLASS_FAR_LEFT  = 3'd3;
  localparam class_t CLASS_FAR_RIGHT = 3'd4;
  localparam class_t CLASS_SPIN_LEFT = 3'd5;

  // One sensor frame
  typedef struct packed {
    sample_t sample_ch0;
    sample_t sample_ch1;
    sample_t sample_ch2;
    sample_t sample_ch3;
    sample_t sample_ch4;
    sample_t sample_ch5;
    sample_t sample_ch6;
    sample_t sample_ch7;
    sample_t sample_ch8;
    sample_t sample_ch9;
    sample_t sample_ch10;
    sample_t sample_ch11;
  } frame_t;

  // One classification result
  typedef struct packed {
    class_t steer_class;
    class_t prior_class;
    logic   cross_hold;
    above_t above_bits;
  } result_t;

  // Floor of x/3 by reciprocal multiply; exact for every 16-bit x
  localparam logic [16:0] RECIP3 = 17'h0AAAB;

  function automatic logic [15:0] div3(input logic [15:0] x);
    logic [32:0] prod;
    begin
      prod = 33'(x) * 33'(RECIP3);
      return prod[32:17];
    end
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/lssc_frame_if.sv */
// ----------------------------------------------------------------------------
// lssc_frame_if
// Valid/ready channel carrying one sensor frame per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface lssc_frame_if;
  import lssc_pkg::*;

  logic   valid;
  logic   ready;
  frame_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/lssc_result_if.sv */
// ----------------------------------------------------------------------------
// lssc_result_if
// Valid/ready channel carrying one classification result per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface lssc_result_if;
  import lssc_pkg::*;

  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/lssc_channel.sv */
// ----------------------------------------------------------------------------
// lssc_channel
// One sensor lane: running max/min stores and the adaptive threshold compare.
// ----------------------------------------------------------------------------
`default_nettype none

module lssc_channel #(
  parameter int SAMPLE_BITS = 10
) (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     take,
  input  wire lssc_pkg::sample_t  raw,
  output logic                    above
);
  import lssc_pkg::*;

  localparam int USE_BITS =
    (SAMPLE_BITS < SAMPLE_FIELD_BITS) ? SAMPLE_BITS : SAMPLE_FIELD_BITS;

  logic [SAMPLE_BITS-1:0] samp;
  logic [SAMPLE_BITS-1:0] peak;
  logic [SAMPLE_BITS-1:0] peak_next;
  logic [SAMPLE_BITS-1:0] floor_lvl;
  logic [SAMPLE_BITS-1:0] floor_lvl_next;
  logic [SAMPLE_BITS:0]   twice_peak;
  logic [15:0]            thr;

  // Drop sample bits above the configured width
  assign samp = SAMPLE_BITS'(raw[USE_BITS-1:0]);

  // Stores include the current sample before the threshold is formed
  assign peak_next      = (samp > peak)      ? samp : peak;
  assign floor_lvl_next = (samp < floor_lvl) ? samp : floor_lvl;

  // floor(2*max/3) + floor(min/3); never exceeds max, so 16 bits is ample
  assign twice_peak = {peak_next, 1'b0};
  assign thr        = div3(16'(twice_peak)) + div3(16'(floor_lvl_next));
  assign above      = 16'(samp) > thr;

  // Running max/min
  always_ff @(posedge clk) begin
    if (rst) begin
      peak      <= '0;
      floor_lvl <= '1;
    end else if (take) begin
      peak      <= peak_next;
      floor_lvl <= floor_lvl_next;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/line_sensor_steer_classifier.sv */
// ----------------------------------------------------------------------------
// line_sensor_steer_classifier
// Adaptive-threshold line-sensor classifier with steering priority decode.
//
//   channel  | dir | beat contents
//   ---------+-----+-----------------------------------------------------
//   frame    | in  | sample_ch0 .. sample_ch11 (10 bits each)
//   result   | out | steer_class, prior_class, cross_hold, above_bits
//
// Two register stages: frame register, then result register. One frame per
// cycle is sustained while the downstream ready holds. Stores and class
// registers update as a frame moves into the result register. Ready is
// combinational from the downstream ready, so a stalled result only holds
// frames that have nowhere to go. Synchronous reset sets the max stores to
// zero, the min stores to all ones and both class registers to straight.
// ----------------------------------------------------------------------------
`default_nettype none

module line_sensor_steer_classifier #(
  parameter int CHANNEL_COUNT = 12,
  parameter int SAMPLE_BITS   = 10
) (
  input  wire           clk,
  input  wire           rst,
  lssc_frame_if.sink    frame,
  lssc_result_if.source result
);
  import lssc_pkg::*;

  // Frame register
  logic    frame_valid;
  frame_t  frame_q;

  // Result register
  logic    out_valid;
  result_t out_q;

  // Class state; the hold flag lives in the result register
  class_t  class_now;
  class_t  class_before;
  class_t  class_now_next;
  class_t  class_before_next;
  logic    hold_mark_next;

  logic    take;
  above_t  above;
  sample_t raw [MAX_CHANNELS];
  logic    b0, b1, b2, b3, b4, b5;

  // Handshake
  assign take        = frame_valid && (!out_valid || result.ready);
  assign frame.ready = !frame_valid || take;
  assign result.valid = out_valid;
  assign result.data  = out_q;

  // Frame register
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
    end else if (frame.valid && frame.ready) begin
      frame_valid <= 1'b1;
    end else if (take) begin
      frame_valid <= 1'b0;
    end
    if (frame.valid && frame.ready) begin
      frame_q <= frame.data;
    end
  end

  // Lane samples
  assign raw[0]  = frame_q.sample_ch0;
  assign raw[1]  = frame_q.sample_ch1;
  assign raw[2]  = frame_q.sample_ch2;
  assign raw[3]  = frame_q.sample_ch3;
  assign raw[4]  = frame_q.sample_ch4;
  assign raw[5]  = frame_q.sample_ch5;
  assign raw[6]  = frame_q.sample_ch6;
  assign raw[7]  = frame_q.sample_ch7;
  assign raw[8]  = frame_q.sample_ch8;
  assign raw[9]  = frame_q.sample_ch9;
  assign raw[10] = frame_q.sample_ch10;
  assign raw[11] = frame_q.sample_ch11;

  // Threshold lanes; unused channels read as zero
  for (genvar i = 0; i < MAX_CHANNELS; i++) begin : g_lane
    if (i < CHANNEL_COUNT) begin : g_used
      lssc_channel #(
        .SAMPLE_BITS (SAMPLE_BITS)
      ) u_channel (
        .clk   (clk),
        .rst   (rst),
        .take  (take),
        .raw   (raw[i]),
        .above (above[i])
      );
    end else begin : g_unused
      assign above[i] = 1'b0;
    end
  end

  assign b0 = above[0];
  assign b1 = above[1];
  assign b2 = above[2];
  assign b3 = above[3];
  assign b4 = above[4];
  assign b5 = above[5];

  // Priority decode on the six lowest bits (channels 0 to 5)
  always_comb begin
    class_now_next    = class_now;
    class_before_next = class_before;
    hold_mark_next    = 1'b0;
    if (!b2 && b3) begin
      class_before_next = class_now;
      class_now_next    = CLASS_OFF_LEFT;
    end else if (b1 && !b2) begin
      class_before_next = class_now;
      class_now_next    = CLASS_OFF_RIGHT;
    end else if (!b0 && b2) begin
      class_before_next = class_now;
      class_now_next    = CLASS_FAR_LEFT;
    end else if (!b4 && b2) begin
      class_before_next = class_now;
      class_now_next    = CLASS_FAR_RIGHT;
    end else if (b1 && !b5 && (b3 || b2)) begin
      // crossing: both classes held
      hold_mark_next = 1'b1;
    end else if (b0 && b1 && b2 && b3 && b4 && b5) begin
      // spin left lands in both registers
      class_before_next = CLASS_SPIN_LEFT;
      class_now_next    = CLASS_SPIN_LEFT;
    end else begin
      class_before_next = class_now;
      class_now_next    = CLASS_STRAIGHT;
    end
  end

  // Class state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      class_now    <= CLASS_STRAIGHT;
      class_before <= CLASS_STRAIGHT;
      out_valid    <= 1'b0;
    end else if (take) begin
      class_now    <= class_now_next;
      class_before <= class_before_next;
      out_valid    <= 1'b1;
    end else if (result.ready) begin
      out_valid    <= 1'b0;
    end
    if (take) begin
      out_q.steer_class <= class_now_next;
      out_q.prior_class <= class_before_next;
      out_q.cross_hold  <= hold_mark_next;
      out_q.above_bits  <= above;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/lssc_checker.sv */
// ----------------------------------------------------------------------------
// lssc_checker
// Port-level checks on the classifier's result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module lssc_checker #(
  parameter int CHANNEL_COUNT = 12
) (
  input wire                    clk,
  input wire                    rst,
  input wire                    out_valid,
  input wire                    out_ready,
  input wire lssc_pkg::result_t out_data
);
  import lssc_pkg::*;

  // A stalled result beat holds its contents
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // No result beat straight after reset
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // Class codes stay within the defined set
  a_codes: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.steer_class <= CLASS_SPIN_LEFT &&
                  out_data.prior_class <= CLASS_SPIN_LEFT)
    else $error("class code out of range");

  // Spin left can only appear with the previous class also spin left
  a_spin: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.steer_class == CLASS_SPIN_LEFT |->
      out_data.prior_class == CLASS_SPIN_LEFT)
    else $error("spin left without matching prior class");

  // Channels beyond the configured count never report a hit
  a_unused: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.above_bits >> CHANNEL_COUNT) == '0)
    else $error("hit on unused channel");

endmodule

bind line_sensor_steer_classifier lssc_checker #(
  .CHANNEL_COUNT (CHANNEL_COUNT)
) u_lssc_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .out_data  (result.data)
);

`default_nettype wire
